// ===== rtl/nlsu_pkg.sv =====
package nlsu_pkg;

    // Largest odd divisor of the series; the last term used is y^d/d with d not above this.
    localparam int MAX_DIVISOR = 255;

    // Fraction bits of the working format (Q2.30).
    localparam int FRAC_BITS = 30;

    // Divisor counter width: it must hold MAX_DIVISOR + 2 after the last step.
    localparam int D_W = $clog2(MAX_DIVISOR + 3);

    // Step counter of the bit-serial divider.
    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

    localparam int OPERAND_W = 32;
    localparam int RESULT_W  = 32;
    localparam int THRESH_W  = 20;
    localparam int DIVISOR_W = OPERAND_W + 1;
    localparam int REM_W     = DIVISOR_W + 1;
    localparam int ACC_W     = FRAC_BITS + 4;

    localparam logic [THRESH_W-1:0]  THRESH_RESET = 20'd1074;
    localparam logic [DIVISOR_W-1:0] ONE_Q16      = 33'h0_0001_0000;
    localparam logic [RESULT_W-1:0]  MOST_NEG     = 32'h8000_0000;
    localparam logic [D_W-1:0]       FIRST_DIV    = D_W'(3);
    localparam logic [D_W-1:0]       LAST_DIV     = D_W'(MAX_DIVISOR);

    typedef enum logic [2:0] {
        S_IDLE,
        S_YDIV,
        S_SQR,
        S_POW,
        S_TDIV,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// ===== rtl/natural_log_series_unit_core.sv =====
// Natural logarithm unit, series form.
// Input stream: s_axis_tdata carries x as unsigned Q16.16; one transaction is
// one argument. Output stream: m_axis_tdata carries ln(x) as signed Q8.24 and
// m_axis_tuser flags a zero argument, for which the data is the most negative
// value. Configuration: i_cfg_wr_en writes i_cfg_wr_data into the early-stop
// threshold (units of 2^-30) at a clock edge; the user must write it only while
// the unit is idle, as the unit itself does not enforce this.
// The unit computes y = (x-1)/(x+1) with a bit-serial divider, squares it on
// the shared 30x30 multiplier, then for each odd divisor d from 3 up to
// MAX_DIVISOR, until a term falls below the threshold, does a multiply, a
// divide on the same divider and an accumulate. A zero argument skips all of
// this. One argument is in work at a time.
// The finished result sits in an output register; a new argument is accepted
// as soon as the sequencer is idle, even while that result still waits. When
// the receiver stalls, the next result waits in the sequencer until the
// output register is free. Reset (synchronous, active low) empties both
// sides and restores the threshold to 1074 (about 1e-6).
module natural_log_series_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: early-stop threshold.
    input  logic        i_cfg_wr_en,
    input  logic [19:0] i_cfg_wr_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] logarithm
    output logic        m_axis_tuser    // [0] domain_error
);

    localparam int F  = nlsu_pkg::FRAC_BITS;
    localparam int DW = nlsu_pkg::DIVISOR_W;
    localparam int RW = nlsu_pkg::REM_W;
    localparam int AW = nlsu_pkg::ACC_W;

    // Sequencer state and loop control.
    nlsu_pkg::t_state r_state, n_state;
    logic [nlsu_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [nlsu_pkg::D_W-1:0]   r_d, n_d;
    logic [nlsu_pkg::THRESH_W-1:0] r_thresh;

    // Shared divider: remainder, quotient/dividend shift register, divisor.
    logic [RW-1:0] r_rem, n_rem;
    logic [F-1:0]  r_quo, n_quo;
    logic [DW-1:0] r_div, n_div;

    // Series values.
    logic [F-1:0]  r_sq, n_sq;
    logic [F-1:0]  r_pow, n_pow;
    logic [AW-1:0] r_acc, n_acc;
    logic          r_neg, n_neg;
    logic          r_err, n_err;

    // Output register.
    logic                          r_ovalid, n_ovalid;
    logic [nlsu_pkg::RESULT_W-1:0] r_odata, n_odata;
    logic                          r_ouser, n_ouser;

    // Combinational helpers.
    logic          accept;
    logic          out_free;
    logic [F-1:0]  mul_a, mul_b;
    logic [2*F-1:0] prod;
    logic [F-1:0]  prod_hi;
    logic [RW-1:0] rem_sh;
    logic [RW:0]   rem_sub;
    logic          rem_ge;
    logic [F-1:0]  term;
    logic          term_small;
    logic [nlsu_pkg::D_W-1:0] d_next;
    logic          last_div;
    logic [DW-1:0] x_ext;
    logic [DW-1:0] diff;
    logic [nlsu_pkg::RESULT_W-1:0] mag;

    assign s_axis_tready = (r_state == nlsu_pkg::S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    // The one multiplier: y*y once, then power*square for every term.
    always_comb begin
        if (r_state == nlsu_pkg::S_SQR) begin
            mul_a = r_quo;
            mul_b = r_quo;
        end else begin
            mul_a = r_pow;
            mul_b = r_sq;
        end
    end
    assign prod    = mul_a * mul_b;
    assign prod_hi = prod[2*F-1:F];

    // One restoring divide step: shift the next dividend bit into the
    // remainder, subtract the divisor when it fits. The remainder always stays
    // below the divisor, so its top bit is zero before the shift.
    assign rem_sh  = {r_rem[RW-2:0], r_quo[F-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b00, r_div};
    assign rem_ge  = !rem_sub[RW];

    assign term       = r_quo;
    assign term_small = {{(F - nlsu_pkg::THRESH_W){1'b0}}, r_thresh} > term;
    assign d_next     = r_d + nlsu_pkg::D_W'(2);
    assign last_div   = d_next > nlsu_pkg::LAST_DIV;

    assign x_ext = {1'b0, s_axis_tdata};
    assign diff  = (x_ext < nlsu_pkg::ONE_Q16) ? (nlsu_pkg::ONE_Q16 - x_ext)
                                                : (x_ext - nlsu_pkg::ONE_Q16);

    // ln x = 2*acc in Q2.30, shifted to Q8.24. The sum stays below 2^32, so
    // the magnitude never reaches the signed limit.
    assign mag = {3'b000, r_acc[AW-1:5]};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nlsu_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tdata == '0) ? nlsu_pkg::S_DONE : nlsu_pkg::S_YDIV;
                end
            end
            nlsu_pkg::S_YDIV: begin
                if (r_cnt == nlsu_pkg::CNT_LAST) begin
                    n_state = nlsu_pkg::S_SQR;
                end
            end
            nlsu_pkg::S_SQR: begin
                n_state = (nlsu_pkg::FIRST_DIV > nlsu_pkg::LAST_DIV) ? nlsu_pkg::S_DONE
                                                                     : nlsu_pkg::S_POW;
            end
            nlsu_pkg::S_POW: begin
                n_state = nlsu_pkg::S_TDIV;
            end
            nlsu_pkg::S_TDIV: begin
                if (r_cnt == nlsu_pkg::CNT_LAST) begin
                    n_state = nlsu_pkg::S_ACC;
                end
            end
            nlsu_pkg::S_ACC: begin
                n_state = (term_small || last_div) ? nlsu_pkg::S_DONE : nlsu_pkg::S_POW;
            end
            nlsu_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = nlsu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nlsu_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb begin
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_sq    = r_sq;
        n_pow   = r_pow;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_err   = r_err;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata = r_odata;
        n_ouser = r_ouser;
        unique case (r_state)
            nlsu_pkg::S_IDLE: begin
                if (accept) begin
                    // Set up |x-1| << 30 / (x+1) with the shifted-in zeros.
                    n_err = (s_axis_tdata == '0);
                    n_neg = (x_ext < nlsu_pkg::ONE_Q16);
                    n_rem = {1'b0, diff};
                    n_quo = '0;
                    n_div = x_ext + nlsu_pkg::ONE_Q16;
                    n_cnt = '0;
                    n_d   = nlsu_pkg::FIRST_DIV;
                end
            end
            nlsu_pkg::S_YDIV, nlsu_pkg::S_TDIV: begin
                n_rem = rem_ge ? rem_sub[RW-1:0] : rem_sh;
                n_quo = {r_quo[F-2:0], rem_ge};
                n_cnt = r_cnt + nlsu_pkg::CNT_W'(1);
            end
            nlsu_pkg::S_SQR: begin
                // r_quo holds |y| here.
                n_sq  = prod_hi;
                n_pow = r_quo;
                n_acc = {{(AW - F){1'b0}}, r_quo};
            end
            nlsu_pkg::S_POW: begin
                // Next odd power, and load it straight into the divider.
                n_pow = prod_hi;
                n_quo = prod_hi;
                n_rem = '0;
                n_div = {{(DW - nlsu_pkg::D_W){1'b0}}, r_d};
                n_cnt = '0;
            end
            nlsu_pkg::S_ACC: begin
                if (!term_small) begin
                    n_acc = r_acc + {{(AW - F){1'b0}}, term};
                    n_d   = d_next;
                end
            end
            nlsu_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_err;
                    if (r_err) begin
                        n_odata = nlsu_pkg::MOST_NEG;
                    end else begin
                        n_odata = r_neg ? (nlsu_pkg::RESULT_W'(0) - mag) : mag;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nlsu_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_thresh <= nlsu_pkg::THRESH_RESET;
            r_d      <= nlsu_pkg::FIRST_DIV;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_d      <= n_d;
            r_cnt    <= n_cnt;
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_div   <= n_div;
        r_sq    <= n_sq;
        r_pow   <= n_pow;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_err   <= n_err;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

`ifndef SYNTHESIS
    // The divider remainder stays below the divisor throughout a division.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nlsu_pkg::S_YDIV || r_state == nlsu_pkg::S_TDIV)
            |-> (r_rem < {1'b0, r_div}))
        else $error("divider remainder not below divisor");

    // The series divisor is always odd.
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d[0])
        else $error("series divisor became even");

    // A finished result waits while the output register is still taken.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nlsu_pkg::S_DONE && m_axis_tvalid && !m_axis_tready)
            |=> (r_state == nlsu_pkg::S_DONE))
        else $error("result left the sequencer while output was stalled");

    // A flagged result carries the most negative value.
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == nlsu_pkg::MOST_NEG))
        else $error("domain error without the most negative value");

    // An argument is taken only with the sequencer idle, and work starts next cycle.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready)
            |=> (r_state == nlsu_pkg::S_YDIV || r_state == nlsu_pkg::S_DONE))
        else $error("accepted argument did not start work");
`endif

endmodule
